[src/swm_pkg.sv]
// shared constants and types for the sliding window minimum block
// no dependencies; used by every module under src
package swm_pkg;

   // sample and register widths
   localparam int DATA_W = 32;
   localparam int CFG_W = 5;

   // deepest window the store holds
   localparam int WINDOW_MAX = 16;
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(4);

   // comparator tree, padded up to a power of two with at least one level
   localparam int TREE_LEVELS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int TREE_SIZE = 2 ** TREE_LEVELS;

   // queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // value that never wins a minimum: largest signed sample
   localparam logic [DATA_W-1:0] KEY_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   // one job: the window snapshot, entries outside the length already masked
   typedef logic [WINDOW_MAX-1:0][DATA_W-1:0] win_type;

   // front to queue push word
   typedef struct packed {
      logic    push;
      win_type win;
   } job_push_type;

endpackage

[src/swm_front.sv]
// front end: takes sample words, keeps the window and fill count, decides on a result
// uses swm_pkg; feeds masked window snapshots to swm_fifo
module swm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [swm_pkg::DATA_W-1:0] req_sample,
   input  logic                             req_start_req,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [swm_pkg::CFG_W-1:0]        csr_data,
   input  logic                             fifo_ready,
   output swm_pkg::job_push_type            job_out
);

   logic [swm_pkg::CFG_W-1:0] len_cfg_ff;
   logic [swm_pkg::LEN_W-1:0] fill_ff, fill_in, fill_base;
   logic [swm_pkg::LEN_W-1:0] eff_len;
   logic [swm_pkg::DATA_W-1:0] window_ff [swm_pkg::WINDOW_MAX];
   logic [swm_pkg::DATA_W-1:0] window_in [swm_pkg::WINDOW_MAX];
   logic accept;
   logic emit;

   assign csr_ready = 1'b1;
   assign req_stall = !fifo_ready;
   assign accept = req_valid && fifo_ready;

   // window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= swm_pkg::LEN_RESET;
      end else if (csr_valid) begin
         len_cfg_ff <= csr_data;
      end
   end

   // clamp the length to 1..WINDOW_MAX
   always_comb begin
      if (len_cfg_ff == '0) begin
         eff_len = swm_pkg::LEN_W'(1);
      end else if (32'(len_cfg_ff) > swm_pkg::WINDOW_MAX) begin
         eff_len = swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX);
      end else begin
         eff_len = swm_pkg::LEN_W'(len_cfg_ff);
      end
   end

   // saturating fill count, cleared by a start word
   always_comb begin
      fill_base = req_start_req ? '0 : fill_ff;
      if (32'(fill_base) < swm_pkg::WINDOW_MAX) begin
         fill_in = fill_base + swm_pkg::LEN_W'(1);
      end else begin
         fill_in = fill_base;
      end
      emit = (fill_in >= eff_len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   // shifted window, newest at entry zero
   always_comb begin
      window_in[0] = req_sample;
      for (int i = 1; i < swm_pkg::WINDOW_MAX; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < swm_pkg::WINDOW_MAX; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // snapshot for the back end, entries past the length cannot win
   always_comb begin
      job_out.push = accept && emit;
      for (int i = 0; i < swm_pkg::WINDOW_MAX; i++) begin
         if (i < 32'(eff_len)) begin
            job_out.win[i] = window_in[i];
         end else begin
            job_out.win[i] = swm_pkg::KEY_MAX;
         end
      end
   end

endmodule

[src/swm_fifo.sv]
// short queue of window snapshots between front and back
// uses swm_pkg types
module swm_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::job_push_type job_in,
   output logic                  ready,
   input  logic                  pop,
   output logic                  not_empty,
   output swm_pkg::win_type      head
);

   swm_pkg::win_type entry_ff [swm_pkg::FIFO_DEPTH];
   logic [swm_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [swm_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [swm_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign not_empty = (count_ff != '0);
   assign do_pop = pop && not_empty;
   assign ready = (32'(count_ff) < swm_pkg::FIFO_DEPTH) || do_pop;
   assign head = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (job_in.push) begin
         if (32'(wr_ptr_ff) == swm_pkg::FIFO_DEPTH - 1) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + swm_pkg::FIFO_PTR_W'(1);
         end
      end
      if (do_pop) begin
         if (32'(rd_ptr_ff) == swm_pkg::FIFO_DEPTH - 1) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + swm_pkg::FIFO_PTR_W'(1);
         end
      end
      if (job_in.push && !do_pop) begin
         count_in = count_ff + swm_pkg::FIFO_CNT_W'(1);
      end else if (!job_in.push && do_pop) begin
         count_in = count_ff - swm_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (job_in.push) begin
         entry_ff[wr_ptr_ff] <= job_in.win;
      end
   end

endmodule

[src/swm_back.sv]
// back end: registered comparator tree over one window snapshot per cycle while not stalled
// uses swm_pkg; the root register is the result word
module swm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   input  swm_pkg::win_type                  job_win,
   output logic                              job_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [swm_pkg::DATA_W-1:0] rsp_window_min
);

   // heap numbered nodes: 1 is the root, leaves sit at TREE_SIZE and up
   logic [swm_pkg::DATA_W-1:0] node_ff [1:swm_pkg::TREE_SIZE-1];
   logic [swm_pkg::DATA_W-1:0] node_in [1:swm_pkg::TREE_SIZE-1];
   logic [swm_pkg::DATA_W-1:0] src [2:2*swm_pkg::TREE_SIZE-1];
   logic [swm_pkg::TREE_LEVELS-1:0] valid_ff;
   logic advance;

   // whole tree moves unless a finished word is held up
   assign advance = !(rsp_valid && rsp_stall);
   assign job_pop = advance;
   assign rsp_valid = valid_ff[swm_pkg::TREE_LEVELS-1];
   assign rsp_window_min = node_ff[1];

   // node sources: registered nodes below the root, then padded leaves
   always_comb begin
      for (int i = 2; i < swm_pkg::TREE_SIZE; i++) begin
         src[i] = node_ff[i];
      end
      for (int j = 0; j < swm_pkg::TREE_SIZE; j++) begin
         if (j < swm_pkg::WINDOW_MAX) begin
            src[swm_pkg::TREE_SIZE + j] = job_win[j];
         end else begin
            src[swm_pkg::TREE_SIZE + j] = swm_pkg::KEY_MAX;
         end
      end
   end

   // one signed compare and select per node
   always_comb begin
      for (int i = 1; i < swm_pkg::TREE_SIZE; i++) begin
         if ($signed(src[2*i+1]) < $signed(src[2*i])) begin
            node_in[i] = src[2*i+1];
         end else begin
            node_in[i] = src[2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 1; i < swm_pkg::TREE_SIZE; i++) begin
            node_ff[i] <= node_in[i];
         end
      end
   end

   // level valid bits, leaf level first
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[swm_pkg::TREE_LEVELS-1:0] << 1} | swm_pkg::TREE_LEVELS'(job_valid);
      end
   end

endmodule

[src/sliding_window_minimum.sv]
// sliding window minimum, top level
// depends on swm_pkg, swm_front, swm_fifo and swm_back
//
// req channel: one word per sample (req_sample, req_start_req), taken at a
//   rising edge with req_valid high and req_stall low. req_start_req begins
//   a new sequence with this sample as its first.
// rsp channel: one word rsp_window_min per sample once the current sequence
//   holds window_len samples; taken when rsp_valid is high and rsp_stall low.
// csr channel: csr_data sets window_len (0 acts as 1, above 16 acts as 16);
//   csr_ready is always high. Write only while the block is idle.
// Path: the queue is written at the edge that takes the sample, then the four
//   tree levels load in turn; the root is the output, and rsp_valid rises
//   once the root holds the word.
// Throughput: one sample per cycle; the front takes a word every cycle while
//   the two entry queue has room, the tree a level per cycle when not stalled.
// Reset clears the fill count, queue and tree valid bits, and sets
//   window_len to 4; the first sample after reset opens a sequence.
// When rsp_stall holds a result the tree freezes, the queue fills, and then
//   req_stall rises until the result is taken.
module sliding_window_minimum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [swm_pkg::DATA_W-1:0] req_sample,
   input  logic                              req_start_req,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [swm_pkg::DATA_W-1:0] rsp_window_min,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swm_pkg::CFG_W-1:0]         csr_data
);

   swm_pkg::job_push_type job_push;
   swm_pkg::win_type job_head;
   logic fifo_ready;
   logic fifo_not_empty;
   logic job_pop;

   // front: accept and classify
   swm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_start_req (req_start_req),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fifo_ready    (fifo_ready),
      .job_out       (job_push)
   );

   // queue between the two halves
   swm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .job_in    (job_push),
      .ready     (fifo_ready),
      .pop       (job_pop),
      .not_empty (fifo_not_empty),
      .head      (job_head)
   );

   // back: comparator tree and output register
   swm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (fifo_not_empty),
      .job_win        (job_head),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_min (rsp_window_min)
   );

endmodule

[tb/sv/window_min_checker.sv]
`timescale 1ns / 100ps
// scoreboard for the sliding window minimum: predicts each window_min from accepted samples
// and compares it with the word on the rsp channel; depends on swm_pkg only
module window_min_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [swm_pkg::DATA_W-1:0] req_sample,
   input  logic                              req_start_req,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [swm_pkg::DATA_W-1:0] rsp_window_min,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [swm_pkg::CFG_W-1:0]         csr_data,
   output int                                fail_count,
   output int                                pending_count
);

   // shadow of the block: recent samples newest first, fill level, window length
   logic signed [swm_pkg::DATA_W-1:0] history [swm_pkg::WINDOW_MAX];
   logic [swm_pkg::LEN_W-1:0]         filled;
   logic [swm_pkg::CFG_W-1:0]         window_len;
   logic signed [swm_pkg::DATA_W-1:0] expected_mins [$];
   logic signed [swm_pkg::DATA_W-1:0] oldest;
   int                                fails = 0;

   // shift one sample into the window, queue its minimum once the window is full
   task automatic take_sample(input logic signed [swm_pkg::DATA_W-1:0] value,
                              input logic first);
      int                                span;
      logic signed [swm_pkg::DATA_W-1:0] lowest;
      span = (window_len == 0) ? 1 :
             (window_len > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : window_len;
      if (first)
         filled = '0;
      for (int i = swm_pkg::WINDOW_MAX - 1; i > 0; i--)
         history[i] = history[i-1];
      history[0] = value;
      if (filled < swm_pkg::WINDOW_MAX)
         filled++;
      if (filled >= span) begin
         lowest = history[0];
         for (int i = 1; i < span; i++)
            if (history[i] < lowest)
               lowest = history[i];
         expected_mins = {expected_mins, lowest};
      end
   endtask

   // results are checked before the sample of the same edge is taken;
   // a register write applies from the next sample on
   always @(posedge clock) begin
      if (reset) begin
         window_len = swm_pkg::LEN_RESET;
         filled = '0;
         foreach (history[i])
            history[i] = '0;
         expected_mins.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_mins.size() == 0) begin
               $error("window_min: unexpected word, expected none, actual %0d", rsp_window_min);
               fails++;
            end else begin
               oldest = expected_mins.pop_front();
               if (rsp_window_min !== oldest) begin
                  $error("window_min: expected %0d, actual %0d", oldest, rsp_window_min);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall)
            take_sample(req_sample, req_start_req);
         if (csr_valid && csr_ready)
            window_len = csr_data;
      end
      fail_count <= fails;
      pending_count <= expected_mins.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// top of the sliding window minimum testbench: clock, reset, sample stimulus and verdict
// depends on swm_pkg, sliding_window_minimum and window_min_checker
module tb_top;

   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int TIMEOUT_NS = 10_000_000;
   localparam logic [swm_pkg::CFG_W-1:0] LEN_TOP = '1;
   localparam logic signed [swm_pkg::DATA_W-1:0] SAMPLE_MAX =
      {1'b0, {(swm_pkg::DATA_W-1){1'b1}}};
   localparam logic signed [swm_pkg::DATA_W-1:0] SAMPLE_MIN =
      {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [swm_pkg::DATA_W-1:0] req_sample = '0;
   logic                              req_start_req = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [swm_pkg::DATA_W-1:0] rsp_window_min;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [swm_pkg::CFG_W-1:0]         csr_data = '0;
   int                                fail_count;
   int                                pending_count;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   sliding_window_minimum DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_min (rsp_window_min),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   window_min_checker min_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_window_min (rsp_window_min),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // offer one sample word and hold it until taken
   task automatic send_word(input logic signed [swm_pkg::DATA_W-1:0] value, input logic first);
      req_valid <= 1'b1;
      req_sample <= value;
      req_start_req <= first;
      do @(posedge clock); while (req_stall);
   endtask

   // drain: stop offering, wait for every expected word, then let the pipeline empty
   task automatic settle;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_len(input logic [swm_pkg::CFG_W-1:0] len);
      csr_valid <= 1'b1;
      csr_data <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // receiver: changing stall density, plus a long hold-off every so often while
   // samples are on offer so the block backs up into req_stall
   initial begin
      int hold_left;
      int since_hold;
      int mode_left;
      int stall_pct;
      hold_left = 0;
      since_hold = 1200;
      mode_left = 0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         since_hold++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!reset && req_valid && since_hold > 1500) begin
            hold_left = $urandom_range(60, 200);
            since_hold = 0;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 25;
                  3: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
               mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [swm_pkg::CFG_W-1:0]         len;
      logic signed [swm_pkg::DATA_W-1:0] value;
      logic                              first;
      int                                span;
      int                                seq_left;
      int                                burst_left;
      bit                                gappy;
      seq_left = 0;
      burst_left = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // stream before any start flag, reset length of four, extreme values
      send_word(SAMPLE_MAX, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word('0, 1'b0);
      send_word(-1, 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      // restart discards the old samples
      send_word(-1, 1'b1);
      send_word(32'sh55555555, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(1, 1'b0);
      // zero length acts as one
      settle;
      write_window_len('0);
      send_word(32'shAAAAAAAA, 1'b0);
      send_word(5, 1'b1);
      send_word(-5, 1'b0);
      // length two, then grown mid-sequence beyond the fill level
      settle;
      write_window_len(swm_pkg::CFG_W'(2));
      send_word(100, 1'b1);
      send_word(-100, 1'b0);
      send_word(50, 1'b0);
      settle;
      write_window_len(swm_pkg::CFG_W'(5));
      send_word(7, 1'b0);
      send_word(-7, 1'b0);
      send_word(3, 1'b0);

      // random phases, each with its own window length; sequences carry across phases
      for (int phase = 0; phase < PHASES; phase++) begin
         settle;
         case (phase)
            0: len = swm_pkg::CFG_W'(swm_pkg::WINDOW_MAX);
            1: len = swm_pkg::CFG_W'(1);
            2: len = LEN_TOP;
            3: len = '0;
            4: len = swm_pkg::CFG_W'(swm_pkg::WINDOW_MAX + 1);
            5: len = swm_pkg::CFG_W'(2);
            default: len = swm_pkg::CFG_W'($urandom_range(0, 2 ** swm_pkg::CFG_W - 1));
         endcase
         write_window_len(len);
         span = (len == 0) ? 1 : (len > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : len;
         gappy = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // mostly sequences that fill the window, now and then a short one
            first = (seq_left == 0);
            if (first)
               seq_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span)
                                                      : $urandom_range(span, span * 4 + 8);
            seq_left--;
            case ($urandom_range(0, 9))
               0: value = SAMPLE_MAX;
               1: value = SAMPLE_MIN;
               2, 3, 4: value = $urandom_range(0, 16) - 8;
               default: value = $urandom;
            endcase
            send_word(value, first);
            if (gappy) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 8)) @(posedge clock);
               end else begin
                  burst_left--;
               end
            end
         end
      end

      settle;
      if (fail_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      #TIMEOUT_NS;
      $display("FAILURE");
      $finish;
   end

endmodule

[sliding_window_minimum.f]
src/swm_pkg.sv
src/swm_front.sv
src/swm_fifo.sv
src/swm_back.sv
src/sliding_window_minimum.sv
tb/sv/window_min_checker.sv
tb/sv/tb_top.sv
